// ===== rtl/clkpr_pkg.sv =====
// Shared types and constants for the second-chance (clock) page replacement block.
// Holds the frame cell command struct, the register map and the default sizes.
// No dependencies; every other file imports it.
package clkpr_pkg;

    // Default build sizes
    localparam int DEF_FRAMES    = 16;
    localparam int DEF_PAGE_BITS = 16;

    // Fixed field widths of the result and the configuration register
    localparam int CFG_W       = 5;
    localparam int FRAME_OUT_W = 4;
    localparam int EVICT_W     = 16;

    localparam logic [CFG_W-1:0] CFG_FRAMES_RESET = 5'd16;

    // Register map: one register, indexed by address bit 2
    localparam logic REG_FRAMES_IN_USE = 1'b0;

    // Operation applied by the frame cell that holds the scan token
    typedef enum logic [2:0] {
        CELL_NOP       = 3'd0,
        CELL_SET_REF   = 3'd1,
        CELL_FILL      = 3'd2,
        CELL_REPLACE   = 3'd3,
        CELL_CLEAR_REF = 3'd4
    } t_cell_op;

    // Control broadcast from the sequencer to every frame cell
    typedef struct packed {
        t_cell_op op;
        logic     shift;
        logic     load;
    } t_cell_ctl;

endpackage

// ===== rtl/clkpr_cell.sv =====
// One frame of the clock replacement chain: page, valid flag, reference bit, scan token.
// The token moves from neighbor to neighbor; the token holder applies the broadcast op.
// Depends on clkpr_pkg.
module clkpr_cell #(
    parameter int PAGE_BITS = 16,
    parameter int IW        = 4,
    parameter int CW        = 5,
    parameter int INDEX     = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  clkpr_pkg::t_cell_ctl  i_ctl,
    input  logic [PAGE_BITS-1:0]  i_key,
    input  logic [CW-1:0]         i_n,
    input  logic [IW-1:0]         i_load_idx,
    input  logic                  i_tok_in,
    output logic                  o_tok,
    output logic                  o_hit,
    output logic                  o_empty,
    output logic                  o_ref,
    output logic [PAGE_BITS-1:0]  o_page_sel
);
    import clkpr_pkg::*;

    logic [PAGE_BITS-1:0] r_page;
    logic                 r_valid;
    logic                 r_ref;
    logic                 r_tok;
    logic                 w_active;
    logic                 w_here;

    // Frame takes part only below the managed count
    assign w_active = 32'(INDEX) < 32'(i_n);
    assign w_here   = (i_load_idx == IW'(INDEX));

    // Local lookup flags
    assign o_hit      = w_active & r_valid & (r_page == i_key);
    assign o_empty    = w_active & ~r_valid;
    assign o_tok      = r_tok;
    assign o_ref      = r_tok & r_ref;
    assign o_page_sel = r_tok ? r_page : '0;

    // Advance the token and update flags of the token holder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_ref   <= 1'b0;
            r_tok   <= 1'b0;
        end else begin
            if (i_ctl.load) begin
                r_tok <= w_here;
            end else if (i_ctl.shift) begin
                r_tok <= i_tok_in;
            end
            if (r_tok) begin
                case (i_ctl.op)
                    CELL_SET_REF: begin
                        r_ref <= 1'b1;
                    end
                    CELL_FILL: begin
                        r_valid <= 1'b1;
                        r_ref   <= 1'b1;
                    end
                    CELL_REPLACE: begin
                        r_valid <= 1'b1;
                        r_ref   <= 1'b0;
                    end
                    CELL_CLEAR_REF: begin
                        r_ref <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Store the new page on fill or replace
    always_ff @(posedge i_clk) begin
        if (r_tok && (i_ctl.op == CELL_FILL || i_ctl.op == CELL_REPLACE)) begin
            r_page <= i_key;
        end
    end

endmodule

// ===== rtl/clock_page_replacement_top.sv =====
// Top level of the second-chance (clock) page replacement block.
// Holds the sequencer, the APB register and the chain of clkpr_cell frames.
// Depends on clkpr_pkg and clkpr_cell.
//
//  channel   | handshake            | payload
//  ----------+----------------------+-------------------------------------------------
//  access    | i_start / o_busy     | i_page_number
//  result    | o_valid (one cycle)  | o_hit, o_frame_index, o_evicted_valid,
//            |                      | o_evicted_page
//  config    | psel/penable/pwrite  | paddr, pwdata, prdata (frames_in_use at 0x0)
//
// After acceptance an access passes through the lookup state, then the scan token walks the
// chain one frame per cycle: in ST_FIND to the lowest hit or empty frame, or in ST_SWEEP
// as the clock sweep from the hand. The result strobes in the cycle after the last step.
// Reset is synchronous, active low, and empties all frames at once with no sweep.
// Results cannot be stalled; o_busy holds off new accesses while one is in progress.
module clock_page_replacement_top #(
    parameter int FRAMES    = clkpr_pkg::DEF_FRAMES,
    parameter int PAGE_BITS = clkpr_pkg::DEF_PAGE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [PAGE_BITS-1:0]          i_page_number,
    output logic                          o_valid,
    output logic                          o_hit,
    output logic [clkpr_pkg::FRAME_OUT_W-1:0] o_frame_index,
    output logic                          o_evicted_valid,
    output logic [clkpr_pkg::EVICT_W-1:0] o_evicted_page,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import clkpr_pkg::*;

    localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CW = $clog2(FRAMES + 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_LOOK  = 4'b0010,
        ST_FIND  = 4'b0100,
        ST_SWEEP = 4'b1000
    } t_state;

    t_state               r_state;
    t_state               n_state;
    logic [CFG_W-1:0]     r_cfg;
    logic [PAGE_BITS-1:0] r_key;
    logic [CW-1:0]        r_n;
    logic [IW-1:0]        r_hand;
    logic [IW-1:0]        r_pos;
    logic [IW-1:0]        n_pos;
    logic                 r_mode_hit;

    logic                 r_valid;
    logic                 r_hit;
    logic [FRAME_OUT_W-1:0] r_frame;
    logic                 r_ev_valid;
    logic [EVICT_W-1:0]   r_ev_page;

    t_cell_ctl            w_ctl;
    logic [IW-1:0]        w_load_idx;
    logic [FRAMES-1:0]    w_tok;
    logic [FRAMES-1:0]    w_tok_in;
    logic [FRAMES-1:0]    w_hit;
    logic [FRAMES-1:0]    w_empty;
    logic [FRAMES-1:0]    w_ref;
    logic [PAGE_BITS-1:0] w_page [FRAMES];
    logic [PAGE_BITS-1:0] w_sel_page;
    logic [CW-1:0]        w_n_eff;
    logic [IW-1:0]        w_hand_eff;
    logic [IW-1:0]        w_pos_next;
    logic                 w_wrap;
    logic                 w_sel_flag;
    logic                 w_cfg_wr;
    logic                 w_accept;
    logic                 w_finish;
    logic [31:0]          w_pos32;
    logic [31:0]          w_page32;

    // Configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_FRAMES_IN_USE);
    assign prdata   = (paddr[2] == REG_FRAMES_IN_USE) ? {{(32-CFG_W){1'b0}}, r_cfg} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_FRAMES_RESET;
        end else if (w_cfg_wr) begin
            r_cfg <= pwdata[CFG_W-1:0];
        end
    end

    // Clamp the frame count to 1..FRAMES
    always_comb begin
        if (r_cfg == '0) begin
            w_n_eff = CW'(1);
        end else if (32'(r_cfg) > 32'(FRAMES)) begin
            w_n_eff = CW'(FRAMES);
        end else begin
            w_n_eff = CW'(r_cfg);
        end
    end

    // Hand and position wrap
    assign w_hand_eff = (32'(r_hand) >= 32'(r_n)) ? '0 : r_hand;
    assign w_wrap     = (32'(r_pos) + 32'd1) >= 32'(r_n);
    assign w_pos_next = w_wrap ? '0 : IW'(32'(r_pos) + 32'd1);

    // Token chain: the last active frame hands back to frame 0
    always_comb begin
        w_tok_in[0] = w_wrap;
        for (int i = 1; i < FRAMES; i++) begin
            w_tok_in[i] = w_tok[i-1] & ~w_wrap;
        end
    end

    // Gather the token holder's page
    always_comb begin
        w_sel_page = '0;
        for (int i = 0; i < FRAMES; i++) begin
            w_sel_page = w_sel_page | w_page[i];
        end
    end

    assign w_sel_flag = r_mode_hit ? |(w_tok & w_hit) : |(w_tok & w_empty);
    assign w_accept   = i_start & ~o_busy;
    assign o_busy     = (r_state != ST_IDLE);

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_pos        = r_pos;
        w_ctl.op     = CELL_NOP;
        w_ctl.shift  = 1'b0;
        w_ctl.load   = 1'b0;
        w_load_idx   = '0;
        w_finish     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                w_ctl.load = 1'b1;
                if ((|w_hit) || (|w_empty)) begin
                    w_load_idx = '0;
                    n_pos      = '0;
                    n_state    = ST_FIND;
                end else begin
                    w_load_idx = w_hand_eff;
                    n_pos      = w_hand_eff;
                    n_state    = ST_SWEEP;
                end
            end
            ST_FIND: begin
                if (w_sel_flag) begin
                    w_ctl.op = r_mode_hit ? CELL_SET_REF : CELL_FILL;
                    w_finish = 1'b1;
                    n_state  = ST_IDLE;
                end else begin
                    w_ctl.shift = 1'b1;
                    n_pos       = w_pos_next;
                end
            end
            ST_SWEEP: begin
                if (|(w_tok & w_ref)) begin
                    w_ctl.op    = CELL_CLEAR_REF;
                    w_ctl.shift = 1'b1;
                    n_pos       = w_pos_next;
                end else begin
                    w_ctl.op = CELL_REPLACE;
                    w_finish = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_hand  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_SWEEP && w_finish) begin
                r_hand <= w_pos_next;
            end
        end
    end

    // Latch the access and scan position
    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        if (w_accept) begin
            r_key <= i_page_number;
            r_n   <= w_n_eff;
        end
        if (r_state == ST_LOOK) begin
            r_mode_hit <= |w_hit;
        end
    end

    // Result beat
    assign w_pos32  = 32'(r_pos);
    assign w_page32 = 32'(w_sel_page);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_frame <= w_pos32[FRAME_OUT_W-1:0];
            if (r_state == ST_SWEEP) begin
                r_hit      <= 1'b0;
                r_ev_valid <= 1'b1;
                r_ev_page  <= w_page32[EVICT_W-1:0];
            end else begin
                r_hit      <= r_mode_hit;
                r_ev_valid <= 1'b0;
                r_ev_page  <= '0;
            end
        end
    end

    assign o_valid         = r_valid;
    assign o_hit           = r_hit;
    assign o_frame_index   = r_frame;
    assign o_evicted_valid = r_ev_valid;
    assign o_evicted_page  = r_ev_page;

    // Frame chain
    for (genvar g = 0; g < FRAMES; g++) begin : g_cell
        clkpr_cell #(
            .PAGE_BITS (PAGE_BITS),
            .IW        (IW),
            .CW        (CW),
            .INDEX     (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_key      (r_key),
            .i_n        (r_n),
            .i_load_idx (w_load_idx),
            .i_tok_in   (w_tok_in[g]),
            .o_tok      (w_tok[g]),
            .o_hit      (w_hit[g]),
            .o_empty    (w_empty[g]),
            .o_ref      (w_ref[g]),
            .o_page_sel (w_page[g])
        );
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for clock_page_replacement_top: drives page accesses and frame count writes,
// predicts each access outcome with a second-chance replacement model and checks results.
// Depends on clkpr_pkg and the RTL of clock_page_replacement_top.
module tb_top;
    import clkpr_pkg::*;

    localparam int FRAMES = DEF_FRAMES;
    localparam int PAGE_W = DEF_PAGE_BITS;
    localparam logic [2:0] ADDR_FRAMES_IN_USE = {REG_FRAMES_IN_USE, 2'b00};

    typedef struct packed {
        logic                   hit;
        logic [FRAME_OUT_W-1:0] frame;
        logic                   evicted_valid;
        logic [EVICT_W-1:0]     evicted_page;
    } t_access_outcome;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_start = 1'b0;
    logic                   o_busy;
    logic [PAGE_W-1:0]      i_page_number = '0;
    logic                   o_valid;
    logic                   o_hit;
    logic [FRAME_OUT_W-1:0] o_frame_index;
    logic                   o_evicted_valid;
    logic [EVICT_W-1:0]     o_evicted_page;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [2:0]             paddr = '0;
    logic [31:0]            pwdata = '0;
    logic [31:0]            prdata;
    logic                   pready;

    // Replacement state as the block should hold it
    logic [PAGE_W-1:0] resident_page [FRAMES];
    logic              resident_valid [FRAMES];
    logic              use_flag [FRAMES];
    int                sweep_hand = 0;
    logic [CFG_W-1:0]  frames_cfg = CFG_FRAMES_RESET;

    t_access_outcome expected_outcomes [$];
    int              mismatch_count = 0;
    bit              back_to_back = 1'b0;
    logic [PAGE_W-1:0] working_set [40];

    clock_page_replacement_top #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_W)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_page_number   (i_page_number),
        .o_valid         (o_valid),
        .o_hit           (o_hit),
        .o_frame_index   (o_frame_index),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #10 i_clk = ~i_clk;

    initial begin
        for (int i = 0; i < FRAMES; i++) begin
            resident_page[i]  = '0;
            resident_valid[i] = 1'b0;
            use_flag[i]       = 1'b0;
        end
    end

    // Apply one access to the replacement state and return what the block should report
    function automatic t_access_outcome predict_access(input logic [PAGE_W-1:0] page);
        t_access_outcome r;
        int n;
        int frame;
        int empty;
        int hand;
        bit found;
        bit has_empty;
        n = int'(frames_cfg);
        if (n < 1) n = 1;
        if (n > FRAMES) n = FRAMES;
        frame = 0;
        empty = 0;
        found = 1'b0;
        has_empty = 1'b0;
        r = '0;
        for (int i = 0; i < n; i++) begin
            if (!found && resident_valid[i] && resident_page[i] == page) begin
                found = 1'b1;
                frame = i;
            end
            if (!has_empty && !resident_valid[i]) begin
                has_empty = 1'b1;
                empty = i;
            end
        end
        if (found) begin
            use_flag[frame] = 1'b1;
            r.hit = 1'b1;
        end else if (has_empty) begin
            frame = empty;
            resident_page[frame]  = page;
            resident_valid[frame] = 1'b1;
            use_flag[frame]       = 1'b1;
        end else begin
            // Sweep from the hand, clearing set bits, and replace the first clear frame
            hand = (sweep_hand >= n) ? 0 : sweep_hand;
            for (int guard = 0; guard <= n && use_flag[hand]; guard++) begin
                use_flag[hand] = 1'b0;
                hand = (hand + 1 >= n) ? 0 : hand + 1;
            end
            frame = hand;
            r.evicted_valid = 1'b1;
            r.evicted_page  = resident_page[frame];
            resident_page[frame]  = page;
            resident_valid[frame] = 1'b1;
            use_flag[frame]       = 1'b0;
            sweep_hand = (hand + 1 >= n) ? 0 : hand + 1;
        end
        r.frame = frame[FRAME_OUT_W-1:0];
        return r;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    // Compare each result beat against the oldest pending prediction
    always @(negedge i_clk) begin : result_check
        t_access_outcome want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (expected_outcomes.size() == 0) begin
                $display("%0t: result beat with no access pending, hit %0h frame %0h",
                         $time, o_hit, o_frame_index);
                mismatch_count++;
            end else begin
                want = expected_outcomes.pop_front();
                check_field("hit", 32'(want.hit), 32'(o_hit));
                check_field("frame_index", 32'(want.frame), 32'(o_frame_index));
                check_field("evicted_valid", 32'(want.evicted_valid), 32'(o_evicted_valid));
                check_field("evicted_page", 32'(want.evicted_page), 32'(o_evicted_page));
            end
        end else if (o_valid !== 1'b0 && i_rst_n) begin
            $display("%0t: result strobe unknown", $time);
            mismatch_count++;
        end
    end

    function automatic int draw_gap();
        return back_to_back ? 0 : $urandom_range(0, 8);
    endfunction

    // Present one access after an optional gap and hold it until accepted
    task automatic send_access(input logic [PAGE_W-1:0] page);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start       <= 1'b1;
        i_page_number <= page;
        @(negedge i_clk);
        while (o_busy !== 1'b0) @(negedge i_clk);
        @(posedge i_clk);
        expected_outcomes.push_back(predict_access(page));
    endtask

    // Drop start and hold until every result is in and the block is idle
    task automatic wait_idle();
        i_start <= 1'b0;
        @(negedge i_clk);
        while (expected_outcomes.size() != 0 || o_busy !== 1'b0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // Write the frame count over APB, then read it back
    task automatic set_frame_count(input logic [CFG_W-1:0] value);
        logic [31:0] wdata;
        wait_idle();
        wdata = $urandom();
        wdata[CFG_W-1:0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_FRAMES_IN_USE;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        while (pready !== 1'b1) @(negedge i_clk);
        @(posedge i_clk);
        frames_cfg = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        psel    <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        while (pready !== 1'b1) @(negedge i_clk);
        check_field("frames_in_use readback", {27'd0, value}, prdata);
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Fill every frame from reset, then force a full sweep and a second-chance skip
    task automatic test_fill_and_sweep();
        send_access(16'h0000);
        send_access(16'hFFFF);
        send_access(16'h0000);
        for (int k = 2; k < FRAMES; k++) send_access(PAGE_W'(32'h1000 + k));
        send_access(16'h5A5A);
        send_access(16'hFFFF);
        send_access(16'hA5A5);
    endtask

    // Shrink, clamp and grow the frame count; leave a duplicate resident behind
    task automatic test_frame_count_limits();
        set_frame_count(5'd1);
        send_access(16'h0001);
        set_frame_count(5'd0);
        send_access(16'h0002);
        set_frame_count(5'd31);
        send_access(16'h0001);
        set_frame_count(5'd17);
        send_access(16'h0002);
        set_frame_count(5'd4);
        send_access(16'h1005);
        set_frame_count(5'd16);
        send_access(16'h1005);
    endtask

    // Random traffic over several frame counts, mostly drawn from a small working set
    task automatic test_random_traffic();
        logic [CFG_W-1:0] counts [11];
        int eff;
        int set_size;
        int pick;
        logic [PAGE_W-1:0] page;
        counts = '{5'd16, 5'd1, 5'd5, 5'd0, 5'd31, 5'd8, 5'd17, 5'd2, 5'd12, 5'd3, 5'd16};
        foreach (counts[p]) begin
            set_frame_count(counts[p]);
            eff = (counts[p] == 0) ? 1 : (int'(counts[p]) > FRAMES) ? FRAMES : int'(counts[p]);
            set_size = eff + $urandom_range(1, eff + 2);
            for (int i = 0; i < set_size; i++) working_set[i] = PAGE_W'($urandom());
            back_to_back = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < 128; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 80) page = working_set[$urandom_range(0, set_size - 1)];
                else if (pick < 95) page = PAGE_W'($urandom());
                else page = pick[0] ? 16'hFFFF : 16'h0000;
                send_access(page);
                // Pause now and then until every outcome has come back
                if (i % 47 == 46) wait_idle();
            end
        end
        back_to_back = 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_fill_and_sweep();
        test_frame_count_limits();
        test_random_traffic();
        wait_idle();
        repeat (25) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // End a hung run
    initial begin
        #6_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
